@@ design/dgr_pkg.sv @@
// ----------------------------------------------------------------------------
// dgr_pkg: shared types and constants of the grid raycaster
// Fixed point widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package dgr_pkg;

	localparam int MAP_SIZE  = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAP_BITS  = $clog2(MAP_SIZE);
	localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int ADDR_BITS = 2 * MAP_BITS;
	localparam int DIST_BITS = 8 + FRAC_BITS;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam int CFG_BITS  = 11;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Divider jobs run on the shared unit.
	typedef enum logic [2:0] {
		DIV_CAM,
		DIV_DDX,
		DIV_DDY,
		DIV_DIST,
		DIV_LH
	} div_job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CAM,
		ST_RAY,
		ST_DDX,
		ST_DDY,
		ST_SIDE,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_DIST,
		ST_LH,
		ST_WALL,
		ST_OUT
	} state_t;

	// Status toward the sequencer from the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ design/dgr_if.sv @@
// ----------------------------------------------------------------------------
// dgr_in_if / dgr_out_if: valid-ready channels of the grid raycaster
// Cast and map write words in, column results out.
// ----------------------------------------------------------------------------
interface dgr_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [4:0]         cell_x;
	logic [4:0]         cell_y;
	logic [2:0]         cell_value;
	logic [9:0]         column;
	logic [20:0]        pos_x;
	logic [20:0]        pos_y;
	logic signed [17:0] dir_x;
	logic signed [17:0] dir_y;
	logic signed [17:0] plane_x;
	logic signed [17:0] plane_y;
	modport source (output valid, command, cell_x, cell_y, cell_value, column,
		pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, input ready);
	modport sink (input valid, command, cell_x, cell_y, cell_value, column,
		pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, output ready);
endinterface

interface dgr_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  column_out;
	logic [9:0]  draw_start;
	logic [9:0]  draw_end;
	logic [15:0] line_height;
	logic [2:0]  wall_value;
	logic        side;
	logic [4:0]  hit_x;
	logic [4:0]  hit_y;
	logic [15:0] wall_frac;
	logic        hit_edge;
	modport source (output valid, column_out, draw_start, draw_end, line_height,
		wall_value, side, hit_x, hit_y, wall_frac, hit_edge, input ready);
	modport sink (input valid, column_out, draw_start, draw_end, line_height,
		wall_value, side, hit_x, hit_y, wall_frac, hit_edge, output ready);
endinterface

@@ design/dgr_ram.sv @@
// ----------------------------------------------------------------------------
// dgr_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module dgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ design/dgr_div.sv @@
// ----------------------------------------------------------------------------
// dgr_div: shared restoring divider
// Unsigned 48 by 24 bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dgr_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [47:0]      num,
	input  logic [23:0]      den,
	output logic [47:0]      quo,
	output dgr_pkg::div_stat_t stat
);
	logic [47:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] trial;
	logic [24:0] shifted;

	assign shifted = {rem_q, quo_q[47]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted[23:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ design/dda_grid_raycaster.sv @@
// ----------------------------------------------------------------------------
// dda_grid_raycaster: grid DDA raycaster with a writable 32x32 wall map
// Map writes and column casts in, one result word per cast out.
// ----------------------------------------------------------------------------
// Map writes can follow each other back to back. A cast runs on one shared
// 48-bit restoring divider used for the camera coordinate, both delta
// distances, the perpendicular distance and the line height (a zero ray
// component or a zero distance skips its division), and walks the grid with
// a step, a map read and a test per grid step (the step that leaves the map
// skips the test), up to 2*MAP_SIZE steps. After reset the map RAM is
// cleared, all 1024 cells, during which no word is accepted. The result
// waits in its output register; once it is taken the block passes through
// its output state back to idle, and only then is the next word accepted.
// Configuration writes must come while the block is idle.
module dda_grid_raycaster (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	dgr_in_if.sink      in_ch,
	dgr_out_if.source   out_ch
);
	localparam int F  = dgr_pkg::FRAC_BITS;
	localparam int MB = dgr_pkg::MAP_BITS;
	localparam int DB = dgr_pkg::DIST_BITS;
	localparam int AB = dgr_pkg::ADDR_BITS;

	dgr_pkg::state_t state_q, state_d;

	logic [10:0] width_q, height_q;
	logic [AB:0] clr_q;

	// Cast operands, held for the whole walk.
	logic [9:0]         col_q;
	logic [20:0]        px_q, py_q;
	logic signed [17:0] dx_q, dy_q, plx_q, ply_q;
	logic signed [17:0] rx_q, ry_q;
	logic signed [27:0] cam_q;
	logic [DB-1:0]      ddx_q, ddy_q, sdx_q, sdy_q, dist_q;
	logic signed [MB+1:0] mx_q, my_q;
	logic               side_q, edge_q;
	logic [2:0]         val_q;
	logic [16:0]        lh_q;

	// Shared divider.
	logic        div_start;
	logic [47:0] div_num, div_quo;
	logic [23:0] div_den;
	dgr_pkg::div_stat_t div_stat;

	dgr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.stat  (div_stat)
	);

	// Map RAM: write address from the input word or clear sweep, read from walk.
	logic          ram_we;
	logic [AB-1:0] ram_addr;
	logic [2:0]    ram_wdata, ram_rdata;

	dgr_ram #(.WIDTH(3), .DEPTH(dgr_pkg::MAP_DEPTH)) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic accept;
	assign in_ch.ready = (state_q == dgr_pkg::ST_IDLE) && !out_ch.valid;
	assign accept      = in_ch.valid && in_ch.ready;

	// Helpers: absolute values and sign-aware operands.
	logic [17:0] arx, ary;
	assign arx = rx_q[17] ? 18'(-rx_q) : 18'(rx_q);
	assign ary = ry_q[17] ? 18'(-ry_q) : 18'(ry_q);

	// Ray = dir + floor(plane*cam / 2^F), saturated. One multiplier per axis.
	logic signed [45:0] mulx, muly;
	logic signed [31:0] rsx, rsy;
	assign mulx = 46'(plx_q) * 46'(cam_q);
	assign muly = 46'(ply_q) * 46'(cam_q);
	assign rsx  = 32'(dx_q) + 32'(mulx >>> F);
	assign rsy  = 32'(dy_q) + 32'(muly >>> F);

	function automatic logic signed [17:0] sat18(input logic signed [31:0] v);
		if (v > 32'sd131071) return 18'sd131071;
		if (v < -32'sd131072) return 18'sh20000;
		return 18'(v);
	endfunction

	// First side distances.
	logic [F:0]      ofx, ofy;
	logic [DB+F:0]   spx, spy;
	assign ofx = rx_q[17] ? {1'b0, px_q[F-1:0]} : (17'(1) << F) - {1'b0, px_q[F-1:0]};
	assign ofy = ry_q[17] ? {1'b0, py_q[F-1:0]} : (17'(1) << F) - {1'b0, py_q[F-1:0]};
	assign spx = ofx * ddx_q;
	assign spy = ofy * ddy_q;

	function automatic logic [DB-1:0] satd(input logic [DB+F:0] v);
		return (v > (DB+F+1)'(dgr_pkg::DIST_MAX)) ? dgr_pkg::DIST_MAX : DB'(v);
	endfunction

	// Walk step.
	logic [DB:0] sum_x, sum_y;
	logic        stepx;
	assign stepx = sdx_q < sdy_q;
	assign sum_x = {1'b0, sdx_q} + {1'b0, ddx_q};
	assign sum_y = {1'b0, sdy_q} + {1'b0, ddy_q};

	logic outside;
	assign outside = mx_q[MB+1] || my_q[MB+1] || mx_q[MB] || my_q[MB];

	// Perpendicular distance numerator.
	logic signed [MB+3+F:0] edge_v, numv;
	logic [MB+3+F:0]        anum;
	always_comb begin
		if (!side_q) begin
			edge_v = (MB+4+F)'(mx_q + (rx_q[17] ? 1 : 0)) <<< F;
			numv   = edge_v - (MB+4+F)'(px_q);
		end else begin
			edge_v = (MB+4+F)'(my_q + (ry_q[17] ? 1 : 0)) <<< F;
			numv   = edge_v - (MB+4+F)'(py_q);
		end
		anum = numv[MB+3+F] ? (MB+4+F)'(-numv) : (MB+4+F)'(numv);
	end

	// Wall coordinate.
	logic signed [42:0] wmul;
	logic [F-1:0]       wfrac, frac_m;
	assign wmul  = $signed({1'b0, dist_q}) * (side_q ? rx_q : ry_q);
	assign wfrac = (side_q ? px_q[F-1:0] : py_q[F-1:0]) + F'(wmul >>> F);
	assign frac_m = ((!side_q && !rx_q[17] && rx_q != 0) || (side_q && ry_q[17]))
		? ~wfrac : wfrac;

	// Draw rows.
	logic [15:0] lh16;
	logic [10:0] hh;
	logic signed [17:0] ds_v, de_v;
	assign lh16 = lh_q[16] ? 16'hFFFF : lh_q[15:0];
	assign hh   = height_q >> 1;
	always_comb begin
		ds_v = 18'(hh) - 18'(lh16 >> 1);
		de_v = 18'(lh16 >> 1) + 18'(hh);
		if (de_v >= 18'(height_q)) de_v = 18'(height_q) - 18'sd1;
	end

	// Divider operand select.
	always_comb begin
		div_num = '0;
		div_den = 24'd1;
		unique case (state_q)
			dgr_pkg::ST_CAM: begin
				div_num = 48'(col_q) << (F + 1);
				div_den = (width_q == 0) ? 24'd1 : 24'(width_q);
			end
			dgr_pkg::ST_DDX: begin
				div_num = 48'(1) << (2 * F);
				div_den = 24'(arx);
			end
			dgr_pkg::ST_DDY: begin
				div_num = 48'(1) << (2 * F);
				div_den = 24'(ary);
			end
			dgr_pkg::ST_DIST: begin
				div_num = 48'(anum) << F;
				div_den = 24'(side_q ? ary : arx);
			end
			dgr_pkg::ST_LH: begin
				div_num = 48'(height_q) << F;
				div_den = dist_q;
			end
			default: ;
		endcase
	end

	logic ent;
	assign ent = !div_stat.busy && !div_stat.done;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dgr_pkg::ST_CLEAR: if (clr_q[AB]) state_d = dgr_pkg::ST_IDLE;
			dgr_pkg::ST_IDLE:
				if (accept && in_ch.command == dgr_pkg::CMD_CAST) state_d = dgr_pkg::ST_CAM;
			dgr_pkg::ST_CAM:  if (div_stat.done) state_d = dgr_pkg::ST_RAY;
			dgr_pkg::ST_RAY:  state_d = dgr_pkg::ST_DDX;
			dgr_pkg::ST_DDX:  if (div_stat.done || (ent && rx_q == 0)) state_d = dgr_pkg::ST_DDY;
			dgr_pkg::ST_DDY:  if (div_stat.done || (ent && ry_q == 0)) state_d = dgr_pkg::ST_SIDE;
			dgr_pkg::ST_SIDE: state_d = dgr_pkg::ST_STEP;
			dgr_pkg::ST_STEP: state_d = dgr_pkg::ST_READ;
			dgr_pkg::ST_READ: state_d = outside ? dgr_pkg::ST_DIST : dgr_pkg::ST_CHECK;
			dgr_pkg::ST_CHECK:
				state_d = (ram_rdata != 0) ? dgr_pkg::ST_DIST : dgr_pkg::ST_STEP;
			dgr_pkg::ST_DIST:
				if (div_stat.done || (ent && (side_q ? ry_q == 0 : rx_q == 0)))
					state_d = dgr_pkg::ST_LH;
			dgr_pkg::ST_LH:   if (div_stat.done || (ent && dist_q == 0)) state_d = dgr_pkg::ST_WALL;
			dgr_pkg::ST_WALL: state_d = dgr_pkg::ST_OUT;
			dgr_pkg::ST_OUT:  if (!out_ch.valid) state_d = dgr_pkg::ST_IDLE;
			default: state_d = dgr_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: divider start and RAM port.
	always_comb begin
		div_start = 1'b0;
		unique case (state_q)
			dgr_pkg::ST_CAM:  div_start = ent;
			dgr_pkg::ST_DDX:  div_start = ent && rx_q != 0;
			dgr_pkg::ST_DDY:  div_start = ent && ry_q != 0;
			dgr_pkg::ST_DIST: div_start = ent && (side_q ? ry_q != 0 : rx_q != 0);
			dgr_pkg::ST_LH:   div_start = ent && dist_q != 0;
			default: ;
		endcase
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = {mx_q[MB-1:0], my_q[MB-1:0]};
		if (state_q == dgr_pkg::ST_CLEAR) begin
			ram_we   = !clr_q[AB];
			ram_addr = clr_q[AB-1:0];
		end else if (accept && in_ch.command == dgr_pkg::CMD_WRITE) begin
			ram_we    = 1'b1;
			ram_wdata = in_ch.cell_value;
			ram_addr  = {in_ch.cell_x[MB-1:0], in_ch.cell_y[MB-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dgr_pkg::ST_CLEAR;
			clr_q    <= '0;
			width_q  <= 11'd128;
			height_q <= 11'd64;
			out_ch.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dgr_pkg::ST_CLEAR && !clr_q[AB]) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == dgr_pkg::CFG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			else if (state_q == dgr_pkg::ST_WALL) out_ch.valid <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= in_ch.column;
			px_q  <= in_ch.pos_x;
			py_q  <= in_ch.pos_y;
			dx_q  <= in_ch.dir_x;
			dy_q  <= in_ch.dir_y;
			plx_q <= in_ch.plane_x;
			ply_q <= in_ch.plane_y;
		end
		unique case (state_q)
			dgr_pkg::ST_CAM:
				if (div_stat.done) cam_q <= 28'(div_quo) - 28'(1 << F);
			dgr_pkg::ST_RAY: begin
				rx_q <= sat18(rsx);
				ry_q <= sat18(rsy);
			end
			dgr_pkg::ST_DDX:
				if (div_stat.done) ddx_q <= (div_quo > 48'(dgr_pkg::DIST_MAX))
					? dgr_pkg::DIST_MAX : DB'(div_quo);
				else if (ent && rx_q == 0) ddx_q <= dgr_pkg::DIST_MAX;
			dgr_pkg::ST_DDY:
				if (div_stat.done) ddy_q <= (div_quo > 48'(dgr_pkg::DIST_MAX))
					? dgr_pkg::DIST_MAX : DB'(div_quo);
				else if (ent && ry_q == 0) ddy_q <= dgr_pkg::DIST_MAX;
			dgr_pkg::ST_SIDE: begin
				sdx_q  <= satd(spx >> F);
				sdy_q  <= satd(spy >> F);
				mx_q   <= (MB+2)'(px_q[20:F]);
				my_q   <= (MB+2)'(py_q[20:F]);
				edge_q <= 1'b0;
				val_q  <= '0;
			end
			dgr_pkg::ST_STEP:
				if (stepx) begin
					sdx_q  <= sum_x[DB] ? dgr_pkg::DIST_MAX : sum_x[DB-1:0];
					mx_q   <= rx_q[17] ? mx_q - 1'b1 : mx_q + 1'b1;
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sum_y[DB] ? dgr_pkg::DIST_MAX : sum_y[DB-1:0];
					my_q   <= ry_q[17] ? my_q - 1'b1 : my_q + 1'b1;
					side_q <= 1'b1;
				end
			dgr_pkg::ST_READ: if (outside) edge_q <= 1'b1;
			dgr_pkg::ST_CHECK: val_q <= ram_rdata;
			dgr_pkg::ST_DIST:
				if (div_stat.done) dist_q <= (div_quo > 48'(dgr_pkg::DIST_MAX))
					? dgr_pkg::DIST_MAX : DB'(div_quo);
				else if (ent && (side_q ? ry_q == 0 : rx_q == 0)) dist_q <= dgr_pkg::DIST_MAX;
			dgr_pkg::ST_LH:
				if (div_stat.done) lh_q <= (div_quo > 48'hFFFF) ? 17'h0FFFF : 17'(div_quo);
				else if (ent && dist_q == 0) lh_q <= 17'h0FFFF;
			dgr_pkg::ST_WALL: begin
				out_ch.column_out  <= col_q;
				out_ch.line_height <= lh16;
				out_ch.draw_start  <= ds_v[17] ? 10'd0 : (ds_v > 18'sd1023 ? 10'd1023 : 10'(ds_v));
				out_ch.draw_end    <= de_v[17] ? 10'd0 : (de_v > 18'sd1023 ? 10'd1023 : 10'(de_v));
				out_ch.wall_value  <= val_q;
				out_ch.side        <= side_q;
				out_ch.hit_x       <= 5'(mx_q);
				out_ch.hit_y       <= 5'(my_q);
				out_ch.wall_frac   <= 16'(frac_m);
				out_ch.hit_edge    <= edge_q;
			end
			default: ;
		endcase
	end

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == dgr_pkg::ST_IDLE) else $error("word taken while busy");
	ap_edge_no_val: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.hit_edge) |-> out_ch.wall_value == 0)
		else $error("edge hit with wall value");
	ap_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider restarted");
endmodule
